FILE: design/ijh_pkg.sv
// Shared types and constants for the interval jitter histogram.
package ijh_pkg;

    localparam int          BINS_DEF     = 64;
    localparam logic [31:0] PERIOD_RESET = 32'd80000;
    localparam int          JIT_W        = 30;

    typedef enum logic {
        FUNC_EVENT = 1'b0,
        FUNC_READ  = 1'b1
    } t_func;

    typedef struct packed {
        t_func       func;
        logic [31:0] timestamp;
        logic [5:0]  bin_index;
    } t_ijh_in;

    typedef struct packed {
        logic [JIT_W-1:0] jitter;
        logic             jitter_valid;
        logic [JIT_W-1:0] max_jitter;
        logic [31:0]      bin_count;
    } t_ijh_out;

endpackage

FILE: design/ijh_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ijh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read returns the old contents on a same-address write
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/interval_jitter_histogram_top.sv
// Interval jitter histogram: top level with measurement pipeline and bin RAM.
//
// Input channel (i_valid / o_stall / i_data) carries event and read items;
// a transaction completes on a rising edge with valid high and stall low.
// An event (func = FUNC_EVENT) takes the interval since the previous event,
// forms |interval - period|, rounds and divides by 8, tracks the maximum and
// bumps one histogram bin (the last bin collects everything beyond it).
// The first event after reset only records its timestamp. A read
// (func = FUNC_READ) returns one bin count; reads beyond the bins give 0.
// Every item gives exactly one result on o_valid / i_stall / o_data.
// Throughput: one item per cycle while the receiver does not stall; the bin
// count is read from the bin RAM as an item leaves stage 1 and written back as
// it leaves stage 2 (forwarding covers back-to-back hits on the same bin).
// When i_stall holds a result, the pipeline keeps filling and o_stall rises
// once all three stages are full.
// After reset the bin RAM is swept to zero, one bin per cycle, with o_stall
// high meanwhile. period (i_cfg_we / i_cfg_wdata) resets to 80000 and may be
// written any time the block is idle.
module interval_jitter_histogram_top #(
    parameter int BINS = ijh_pkg::BINS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [31:0]      i_cfg_wdata,
    input  logic             i_valid,
    output logic             o_stall,
    input  ijh_pkg::t_ijh_in i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output ijh_pkg::t_ijh_out o_data
);
    import ijh_pkg::*;

    localparam int            AW       = $clog2(BINS);
    localparam logic [AW-1:0] LAST_BIN = AW'(BINS - 1);

    // config and event history
    logic [31:0]      r_period;
    logic [31:0]      r_last;
    logic             r_seen;
    logic [JIT_W-1:0] r_max;

    // clearing sweep
    logic             r_clr_busy;
    logic [AW-1:0]    r_clr_addr;

    // stage 1: deviation
    logic             r_s1_v;
    t_func            r_s1_func;
    logic             r_s1_meas;
    logic [31:0]      r_s1_dev;
    logic [5:0]       r_s1_idx;

    // stage 2: RAM data back
    logic             r_s2_v;
    t_func            r_s2_func;
    logic             r_s2_meas;
    logic [JIT_W-1:0] r_s2_jit;
    logic [AW-1:0]    r_s2_addr;
    logic             r_s2_inrange;

    // output register
    logic             r_out_v;
    t_ijh_out         r_out;

    // last RAM write, for forwarding
    logic             r_fwd_v;
    logic [AW-1:0]    r_fwd_addr;
    logic [31:0]      r_fwd_data;

    logic             w_out_adv, w_s2_adv, w_s2_free, w_s1_adv, w_s1_free, w_in_acc;
    logic [31:0]      w_interval;
    logic [31:0]      n_s1_dev;
    logic [JIT_W-1:0] n_s2_jit;
    logic [AW-1:0]    w_bin;
    logic [AW-1:0]    n_s2_addr;
    logic             n_s2_inrange;
    logic [31:0]      w_rdata;
    logic             w_hit;
    logic [31:0]      w_cur;
    logic [JIT_W-1:0] n_max;
    t_ijh_out         n_out;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [31:0]      w_wdata;

    // pipeline flow
    assign w_out_adv = !r_out_v || !i_stall;
    assign w_s2_adv  = r_s2_v && w_out_adv;
    assign w_s2_free = !r_s2_v || w_out_adv;
    assign w_s1_adv  = r_s1_v && w_s2_free;
    assign w_s1_free = !r_s1_v || w_s2_free;
    assign o_stall   = r_clr_busy || !w_s1_free;
    assign w_in_acc  = i_valid && !o_stall;

    // stage 0: modular interval and absolute deviation from period
    always_comb begin
        w_interval = i_data.timestamp - r_last;
        if (w_interval > r_period) begin
            n_s1_dev = w_interval - r_period;
        end else begin
            n_s1_dev = r_period - w_interval;
        end
    end

    // stage 1: round, divide by 8, pick the bin
    always_comb begin
        n_s2_jit = JIT_W'((33'(r_s1_dev) + 33'd4) >> 3);
        if (n_s2_jit >= JIT_W'(BINS - 1)) begin
            w_bin = LAST_BIN;
        end else begin
            w_bin = AW'(n_s2_jit);
        end
        n_s2_addr    = (r_s1_func == FUNC_READ) ? AW'(r_s1_idx) : w_bin;
        n_s2_inrange = {26'd0, r_s1_idx} < 32'(BINS);
    end

    ijh_ram #(
        .WIDTH (32),
        .DEPTH (BINS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_s1_adv),
        .i_raddr (n_s2_addr),
        .o_rdata (w_rdata)
    );

    // stage 2: count update and result
    always_comb begin
        w_hit = r_fwd_v && (r_fwd_addr == r_s2_addr);
        w_cur = w_hit ? r_fwd_data : w_rdata;
        n_max = (r_s2_meas && (r_s2_jit > r_max)) ? r_s2_jit : r_max;

        n_out.jitter       = r_s2_meas ? r_s2_jit : '0;
        n_out.jitter_valid = r_s2_meas;
        n_out.max_jitter   = n_max;
        n_out.bin_count    = ((r_s2_func == FUNC_READ) && r_s2_inrange) ? w_cur : 32'd0;

        w_we    = r_clr_busy || (w_s2_adv && r_s2_meas);
        w_waddr = r_clr_busy ? r_clr_addr : r_s2_addr;
        w_wdata = r_clr_busy ? 32'd0 : (w_cur + 32'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period   <= PERIOD_RESET;
            r_last     <= '0;
            r_seen     <= 1'b0;
            r_max      <= '0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_out_v    <= 1'b0;
            r_fwd_v    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
            end
            if (r_clr_busy) begin
                if (r_clr_addr == LAST_BIN) begin
                    r_clr_busy <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                end
            end
            if (w_in_acc && (i_data.func == FUNC_EVENT)) begin
                r_last <= i_data.timestamp;
                r_seen <= 1'b1;
            end
            if (w_s2_adv) begin
                r_max <= n_max;
            end
            if (w_we) begin
                r_fwd_v <= 1'b1;
            end
            r_s1_v  <= w_in_acc || (r_s1_v && !w_s1_adv);
            r_s2_v  <= w_s1_adv || (r_s2_v && !w_s2_adv);
            r_out_v <= w_s2_adv || (r_out_v && i_stall);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_func <= i_data.func;
            r_s1_meas <= (i_data.func == FUNC_EVENT) && r_seen;
            r_s1_dev  <= n_s1_dev;
            r_s1_idx  <= i_data.bin_index;
        end
        if (w_s1_adv) begin
            r_s2_func    <= r_s1_func;
            r_s2_meas    <= r_s1_meas;
            r_s2_jit     <= n_s2_jit;
            r_s2_addr    <= n_s2_addr;
            r_s2_inrange <= n_s2_inrange;
        end
        if (w_s2_adv) begin
            r_out <= n_out;
        end
        if (w_we) begin
            r_fwd_addr <= w_waddr;
            r_fwd_data <= w_wdata;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

    // pipeline stays empty throughout the clearing sweep
    a_clr_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (!r_s1_v && !r_s2_v && !r_out_v))
        else $error("item in flight during bin clearing");

    // the running maximum never falls below the jitter it reports with
    a_max_ge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.jitter_valid) |-> (r_out.max_jitter >= r_out.jitter))
        else $error("max_jitter below jitter");

    // a bin is only incremented by a measured event leaving stage 2
    a_we_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && !r_clr_busy) |-> (r_s2_v && r_s2_meas && (r_s2_func == FUNC_EVENT)))
        else $error("bin write without a measured event");

    // results only appear after the sweep has finished
    a_out_after_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_v) |-> !$past(r_clr_busy, 3))
        else $error("result produced during clearing");

endmodule

FILE: bench/ijh_checker.sv
// Jitter histogram checker: watches both channels, predicts each result and compares.
module ijh_checker #(
    parameter int BINS = ijh_pkg::BINS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [31:0]       i_cfg_wdata,
    input  logic              i_valid,
    input  logic              i_stall_in,
    input  ijh_pkg::t_ijh_in  i_data,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  ijh_pkg::t_ijh_out i_out_data,
    output int                o_fail_count,
    output int                o_due_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import ijh_pkg::*;

    logic [31:0]      period;
    logic [31:0]      last_time;
    logic             seen_first;
    logic [JIT_W-1:0] max_seen;
    logic [31:0]      histogram [BINS];
    t_ijh_out         due_results [$];
    int               fail_count;
    int               result_no;

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    // Rounded deviation over 8; done at 33 bits so the +4 cannot wrap.
    function automatic logic [JIT_W-1:0] jitter_of(input logic [31:0] interval,
                                                   input logic [31:0] per);
        logic [32:0] dev;
        dev = (interval > per) ? {1'b0, interval - per} : {1'b0, per - interval};
        dev = dev + 33'd4;
        return dev[32:3];
    endfunction

    task automatic account_item(input t_ijh_in item);
        t_ijh_out         res;
        logic [JIT_W-1:0] jit;
        int               bin;
        res = '0;
        if (item.func == FUNC_EVENT) begin
            if (seen_first) begin
                jit = jitter_of(item.timestamp - last_time, period);
                res.jitter       = jit;
                res.jitter_valid = 1'b1;
                if (jit > max_seen) max_seen = jit;
                // everything at or past the last bin lands in it
                bin = (jit >= BINS - 1) ? BINS - 1 : int'(jit);
                histogram[bin] = histogram[bin] + 32'd1;
            end
            seen_first = 1'b1;
            last_time  = item.timestamp;
        end else if (item.bin_index < BINS) begin
            res.bin_count = histogram[item.bin_index];
        end
        res.max_jitter = max_seen;
        due_results.push_back(res);
    endtask

    task automatic check_result(input t_ijh_out got);
        t_ijh_out want;
        if (due_results.size() == 0) begin
            report($sformatf("result %0d arrived with nothing expected", result_no));
        end else begin
            want = due_results.pop_front();
            if (got.jitter !== want.jitter)
                report($sformatf("result %0d jitter %0h, expected %0h",
                                 result_no, got.jitter, want.jitter));
            if (got.jitter_valid !== want.jitter_valid)
                report($sformatf("result %0d jitter_valid %0b, expected %0b",
                                 result_no, got.jitter_valid, want.jitter_valid));
            if (got.max_jitter !== want.max_jitter)
                report($sformatf("result %0d max_jitter %0h, expected %0h",
                                 result_no, got.max_jitter, want.max_jitter));
            if (got.bin_count !== want.bin_count)
                report($sformatf("result %0d bin_count %0h, expected %0h",
                                 result_no, got.bin_count, want.bin_count));
        end
        result_no++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            period     = PERIOD_RESET;
            last_time  = '0;
            seen_first = 1'b0;
            max_seen   = '0;
            for (int b = 0; b < BINS; b++) histogram[b] = '0;
            due_results.delete();
        end else begin
            if (i_cfg_we) period = i_cfg_wdata;
            if (i_out_valid && !i_out_stall) check_result(i_out_data);
            if (i_valid && !i_stall_in) account_item(i_data);
        end
        o_due_count  <= due_results.size();
        o_fail_count <= fail_count;
    end

endmodule

FILE: bench/tb.sv
// Testbench top: stimulus, receiver stalls, watchdog and verdict for the jitter histogram.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ijh_pkg::*;

    localparam int IDLE_LIMIT  = 3000;
    localparam int PHASE_ITEMS = 270;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        i_valid     = 1'b0;
    logic        o_stall;
    t_ijh_in     i_data      = '0;
    logic        o_valid;
    logic        i_stall     = 1'b0;
    t_ijh_out    o_data;

    int          fail_count;
    int          due_count;
    int          idle_cycles;
    int          burst_left  = 0;
    bit          gaps_on     = 1'b1;
    logic [31:0] cur_period  = PERIOD_RESET;
    logic [31:0] last_ts     = '0;
    int          stall_mode  = 0;
    int          seg_left    = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    interval_jitter_histogram_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data)
    );

    ijh_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .i_stall_in   (o_stall),
        .i_data       (i_data),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_data   (o_data),
        .o_fail_count (fail_count),
        .o_due_count  (due_count)
    );

    // Receiver stall pattern: segments of no stall, light, heavy and periodic stalling
    always @(posedge i_clk) begin
        if (seg_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            seg_left   = $urandom_range(50, 300);
        end
        seg_left--;
        unique case (stall_mode)
            0: begin
                i_stall <= 1'b0;
            end
            1: begin
                i_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
                i_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                i_stall <= ((seg_left % 16) < 6);
            end
        endcase
    end

    task automatic send(input t_ijh_in d);
        int gap;
        if (burst_left == 0) begin
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_valid <= 1'b1;
        i_data  <= d;
        do @(posedge i_clk); while (o_stall);
        burst_left--;
    endtask

    task automatic send_event(input logic [31:0] ts);
        t_ijh_in d;
        d.func      = FUNC_EVENT;
        d.timestamp = ts;
        d.bin_index = 6'($urandom_range(0, 63));
        last_ts = ts;
        send(d);
    endtask

    task automatic send_read(input logic [5:0] idx);
        t_ijh_in d;
        d.func      = FUNC_READ;
        d.timestamp = $urandom();
        d.bin_index = idx;
        send(d);
    endtask

    // Let every outstanding result come back, then allow for the pipeline depth
    task automatic drain();
        i_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (due_count != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_period(input logic [31:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_period = value;
    endtask

    task automatic run_random(input int n);
        int          k;
        logic [31:0] off;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 58) begin
                if (k < 10) begin
                    send_event($urandom());
                end else if (k < 20) begin
                    send_event(last_ts + cur_period);
                end else if (k < 85) begin
                    off = $urandom_range(0, 8 * 70);
                    if ($urandom_range(0, 1))
                        send_event(last_ts + cur_period + off);
                    else
                        send_event(last_ts + cur_period - off);
                end else begin
                    off = $urandom_range(0, 1 << 22);
                    if ($urandom_range(0, 1))
                        send_event(last_ts + cur_period + off);
                    else
                        send_event(last_ts + cur_period - off);
                end
            end else begin
                if (k < 25)
                    send_read(6'd63);
                else if (k < 60)
                    send_read(6'($urandom_range(0, 8)));
                else
                    send_read(6'($urandom_range(0, 63)));
            end
        end
    endtask

    initial begin : watchdog
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        logic [31:0] periods [6];
        periods = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'd1000, 32'd0, 32'd80000};
        periods[4] = $urandom();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset period: empty histogram, first event, rounding edges, last bin
        send_read(6'd0);
        send_read(6'd63);
        send_event(32'd100);
        send_event(last_ts + 32'd80000);
        send_event(last_ts + 32'd80003);
        send_event(last_ts + 32'd80004);
        send_event(last_ts + 32'd79996);
        send_event(last_ts + 32'd80000 + 32'd8 * 62);
        send_event(last_ts + 32'd80000 + 32'd8 * 63);
        send_event(last_ts + 32'd80000 + 32'd8 * 100);
        send_event(32'hFFFF_FFF0);
        send_event(last_ts + 32'd80000);
        send_event(last_ts + 32'd80000);
        send_read(6'd0);
        send_read(6'd1);
        send_read(6'd62);
        send_read(6'd63);
        drain();

        // Zero period: deviation equals the interval, full-scale interval gives 2^29
        set_period(32'd0);
        send_event(last_ts + 32'hFFFF_FFFF);
        send_event(last_ts);
        send_read(6'd63);
        drain();
        // Full-scale period with a zero interval
        set_period(32'hFFFF_FFFF);
        send_event(last_ts);
        send_event(last_ts + 32'hFFFF_FFFF);
        send_read(6'd63);
        send_read(6'd0);
        drain();

        // Random phases over several periods, sender gaps off in some
        foreach (periods[p]) begin
            set_period(periods[p]);
            gaps_on = (p % 3 != 1);
            run_random(PHASE_ITEMS);
            drain();
        end

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: files.f
design/ijh_pkg.sv
design/ijh_ram.sv
design/interval_jitter_histogram_top.sv
bench/ijh_checker.sv
bench/tb.sv
